FILE: rtl/foe_pkg.sv
// Package for the formatted output engine: shared constants, types and codes.
// No dependencies.
package foe_pkg;

  localparam int unsigned MaxWidthDefault = 32;
  localparam int unsigned WidthW = 6;

  localparam logic [1:0] ModeFmt = 2'd0;
  localparam logic [1:0] ModeStr = 2'd1;
  localparam logic [1:0] ModeEnd = 2'd2;

  localparam logic [1:0] PhText = 2'd0;
  localparam logic [1:0] PhPct = 2'd1;
  localparam logic [1:0] PhWidth = 2'd2;
  localparam logic [1:0] PhStr = 2'd3;

  localparam logic [31:0] NullLimit = 32'h0000_1000;

  // datapath command
  typedef struct packed {
    logic       load;      // capture item, clear digit buffer
    logic       div_step;  // produce one digit
    logic       emit;      // present one char
    logic [7:0] ch;        // char to emit when use_digit is low
    logic       use_digit; // emit top stored digit
    logic       term;      // terminator result
    logic       last;
  } foe_cmd_t;

  typedef struct packed {
    logic       div_done;  // remaining value is zero or 10 digits made
    logic [3:0] ndig;
    logic       out_busy;  // output register holds an untaken result
    logic       neg;
  } foe_sts_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    hex_char = (d < 4'd10) ? (8'h30 + {4'd0, d}) : (8'h57 + {4'd0, d});
  endfunction

  function automatic logic [7:0] null_char(input logic [2:0] i);
    case (i)
      3'd0: null_char = 8'h28;
      3'd1: null_char = 8'h6e;
      3'd2: null_char = 8'h75;
      3'd3: null_char = 8'h6c;
      3'd4: null_char = 8'h6c;
      default: null_char = 8'h29;
    endcase
  endfunction

endpackage

FILE: rtl/foe_datapath.sv
// Datapath: digit generation (one digit per cycle), digit store, character counter
// and output register. Depends on foe_pkg.
module foe_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic [31:0]       arg_value_i,
  input  logic              hex_i,
  input  logic              signed_i,
  input  foe_pkg::foe_cmd_t cmd_i,
  output foe_pkg::foe_sts_t sts_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [7:0]        out_char_o,
  output logic              in_buffer_o,
  output logic [15:0]       position_o,
  output logic              is_terminator_o,
  output logic [31:0]       char_count_o,
  output logic              last_o
);
  import foe_pkg::*;

  logic [15:0] bsize_q;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] val_q;
  logic        hex_q, neg_q;
  logic [3:0]  dig_q [10];
  logic [3:0]  ndig_q;
  logic        vld_q;
  logic [7:0]  ch_q;
  logic        inb_q, term_q, last_q;
  logic [15:0] pos_q;
  logic [31:0] ccnt_q;

  // divide by 10 via reciprocal multiply (32x32, shift by 35), exact without correction
  logic [66:0] prod;
  logic [31:0] quot, rem10, quot10;
  logic [31:0] qn;
  logic [3:0]  dnext;
  logic [7:0]  ech;
  logic        inb;
  logic [15:0] tpos;

  assign prod   = {35'd0, val_q} * 67'h0_CCCC_CCCD;
  assign quot   = prod[66:35];
  assign quot10 = {quot[28:0], 3'd0} + {quot[30:0], 1'd0};
  assign rem10  = val_q - quot10;
  assign qn     = hex_q ? {4'd0, val_q[31:4]} : quot;
  assign dnext  = hex_q ? val_q[3:0] : rem10[3:0];

  assign ech = cmd_i.use_digit ? hex_char(dig_q[ndig_q - 4'd1]) : cmd_i.ch;
  assign inb = (bsize_q != 16'd0) && (cnt_q < {16'd0, bsize_q - 16'd1});
  assign tpos = (cnt_q < {16'd0, bsize_q}) ? cnt_q[15:0] : bsize_q - 16'd1;

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.emit) begin
      if (cmd_i.term) cnt_d = '0;
      else if (cnt_q != 32'hFFFF_FFFF) cnt_d = cnt_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsize_q <= 16'hFFFF;
      cnt_q   <= '0;
      vld_q   <= 1'b0;
      ndig_q  <= '0;
    end else begin
      if (cfg_we_i) bsize_q <= cfg_wdata_i;
      cnt_q <= cnt_d;
      if (out_ready_i) vld_q <= 1'b0;
      if (cmd_i.emit) vld_q <= 1'b1;
      if (cmd_i.load) ndig_q <= '0;
      else if (cmd_i.div_step) ndig_q <= ndig_q + 4'd1;
      else if (cmd_i.emit && cmd_i.use_digit) ndig_q <= ndig_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hex_q <= hex_i;
      neg_q <= signed_i & arg_value_i[31];
      val_q <= (signed_i & arg_value_i[31]) ? (32'd0 - arg_value_i) : arg_value_i;
    end else if (cmd_i.div_step) begin
      val_q <= qn;
      dig_q[ndig_q] <= dnext;
    end
    if (cmd_i.emit) begin
      ch_q   <= cmd_i.term ? 8'd0 : ech;
      inb_q  <= cmd_i.term ? (bsize_q != 16'd0) : inb;
      pos_q  <= cmd_i.term ? ((bsize_q != 16'd0) ? tpos : 16'd0)
                           : (inb ? cnt_q[15:0] : 16'd0);
      term_q <= cmd_i.term;
      ccnt_q <= cmd_i.term ? cnt_q : cnt_d;
      last_q <= cmd_i.last;
    end
  end

  assign sts_o.div_done = (qn == 32'd0) || (ndig_q == 4'd9);
  assign sts_o.ndig     = ndig_q;
  assign sts_o.out_busy = vld_q & ~out_ready_i;
  assign sts_o.neg      = neg_q;

  assign out_valid_o     = vld_q;
  assign out_char_o      = ch_q;
  assign in_buffer_o     = inb_q;
  assign position_o      = pos_q;
  assign is_terminator_o = term_q;
  assign char_count_o    = ccnt_q;
  assign last_o          = last_q;
endmodule

FILE: rtl/foe_ctrl.sv
// Controller: format parsing state and the sequencer that drives the datapath.
// Depends on foe_pkg.
module foe_ctrl #(
  parameter int unsigned MaxWidth = foe_pkg::MaxWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        mode_i,
  input  logic [7:0]        data_byte_i,
  input  logic [31:0]       arg_value_i,
  output logic              hex_o,
  output logic              signed_o,
  output foe_pkg::foe_cmd_t cmd_o,
  input  foe_pkg::foe_sts_t sts_i
);
  import foe_pkg::*;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SDiv  = 3'd1;
  localparam logic [2:0] SSign = 3'd2;
  localparam logic [2:0] SPad  = 3'd3;
  localparam logic [2:0] SDig  = 3'd4;
  localparam logic [2:0] SNull = 3'd5;
  localparam logic [2:0] SLet  = 3'd6;

  logic [2:0]        st_q, st_d;
  logic [1:0]        ph_q, ph_d;
  logic              zf_q, zf_d;
  logic [WidthW-1:0] w_q, w_d;
  logic [WidthW-1:0] pad_q, pad_d;
  logic [2:0]        ni_q, ni_d;
  logic [7:0]        let_q, let_d;
  logic              acc;
  logic [WidthW+3:0] wacc;
  logic [1:0]        eph;
  logic              busy;

  assign busy       = sts_i.out_busy;
  assign in_ready_o = (st_q == SIdle) && !busy;
  assign acc        = in_valid_i && in_ready_o;
  assign eph        = (ph_q == PhStr) ? PhText : ph_q;
  assign wacc       = {4'd0, w_q} * 10'd10 + {6'd0, data_byte_i[3:0]};
  assign hex_o      = (data_byte_i == 8'h78);
  assign signed_o   = (data_byte_i == 8'h64);

  always_comb begin
    st_d = st_q; ph_d = ph_q; zf_d = zf_q; w_d = w_q; pad_d = pad_q;
    ni_d = ni_q; let_d = let_q;
    cmd_o = '0;
    case (st_q)
      SIdle: if (acc) begin
        case (mode_i)
          ModeStr: if (ph_q == PhStr) begin
            if (data_byte_i == 8'd0) ph_d = PhText;
            else begin cmd_o.emit = 1'b1; cmd_o.ch = data_byte_i; cmd_o.last = 1'b1; end
          end
          ModeEnd: begin
            cmd_o.emit = 1'b1; cmd_o.term = 1'b1; cmd_o.last = 1'b1;
            ph_d = PhText; zf_d = 1'b0; w_d = '0;
          end
          ModeFmt: begin
            ph_d = eph;
            if (eph == PhText) begin
              if (data_byte_i == 8'h25) begin
                ph_d = PhPct; zf_d = 1'b0; w_d = '0;
              end else if (data_byte_i != 8'd0) begin
                cmd_o.emit = 1'b1; cmd_o.ch = data_byte_i; cmd_o.last = 1'b1;
              end
            end else if (eph == PhPct && data_byte_i == 8'h30) begin
              zf_d = 1'b1; ph_d = PhWidth;
            end else if (data_byte_i >= 8'h30 && data_byte_i <= 8'h39) begin
              w_d = (wacc > MaxWidth) ? WidthW'(MaxWidth) : wacc[WidthW-1:0];
              ph_d = PhWidth;
            end else begin
              ph_d = PhText;
              case (data_byte_i)
                8'h64, 8'h75, 8'h78: begin
                  cmd_o.load = 1'b1; st_d = SDiv;
                end
                8'h63: begin
                  cmd_o.emit = 1'b1; cmd_o.ch = arg_value_i[7:0]; cmd_o.last = 1'b1;
                  zf_d = 1'b0; w_d = '0;
                end
                8'h25: begin
                  cmd_o.emit = 1'b1; cmd_o.ch = 8'h25; cmd_o.last = 1'b1;
                  zf_d = 1'b0; w_d = '0;
                end
                8'h73: begin
                  zf_d = 1'b0; w_d = '0;
                  if (arg_value_i < NullLimit) begin ni_d = '0; st_d = SNull; end
                  else ph_d = PhStr;
                end
                8'h00: begin zf_d = 1'b0; w_d = '0; end
                default: begin
                  cmd_o.emit = 1'b1; cmd_o.ch = 8'h25;
                  let_d = data_byte_i; st_d = SLet;
                  zf_d = 1'b0; w_d = '0;
                end
              endcase
            end
          end
          default: ;
        endcase
      end
      SDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) st_d = SSign;
      end
      SSign: begin
        pad_d = ({2'd0, sts_i.ndig} < w_q) ? w_q - {2'd0, sts_i.ndig} : '0;
        if (sts_i.neg && !busy) begin
          cmd_o.emit = 1'b1; cmd_o.ch = 8'h2d; st_d = SPad;
        end else if (!sts_i.neg) st_d = SPad;
      end
      SPad: if (pad_q == '0) st_d = SDig;
        else if (!busy) begin
          cmd_o.emit = 1'b1; cmd_o.ch = zf_q ? 8'h30 : 8'h20;
          pad_d = pad_q - WidthW'(1);
        end
      SDig: if (!busy) begin
        cmd_o.emit = 1'b1; cmd_o.use_digit = 1'b1;
        if (sts_i.ndig == 4'd1) begin
          cmd_o.last = 1'b1; st_d = SIdle; zf_d = 1'b0; w_d = '0;
        end
      end
      SNull: if (!busy) begin
        cmd_o.emit = 1'b1; cmd_o.ch = null_char(ni_q);
        ni_d = ni_q + 3'd1;
        if (ni_q == 3'd5) begin cmd_o.last = 1'b1; st_d = SIdle; end
      end
      SLet: if (!busy) begin
        cmd_o.emit = 1'b1; cmd_o.ch = let_q; cmd_o.last = 1'b1; st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; ph_q <= PhText; zf_q <= 1'b0; w_q <= '0;
      pad_q <= '0; ni_q <= '0; let_q <= '0;
    end else begin
      st_q <= st_d; ph_q <= ph_d; zf_q <= zf_d; w_q <= w_d;
      pad_q <= pad_d; ni_q <= ni_d; let_q <= let_d;
    end
  end
endmodule

FILE: rtl/formatted_output_engine_core.sv
// Top level of the formatted output engine: controller plus datapath.
// Depends on foe_pkg, foe_ctrl, foe_datapath.
//
// Plain text, %c, %% and string bytes each give one char; an unknown letter gives
// two (the percent sign, then the letter) and a null %s six after the accept.
// A numeric conversion passes through the accept, the divide-by-ten unit (one digit per
// step, up to 10), the sign state (a minus if negative), the padding state (up to
// MaxWidth padding chars) and the digit state. Each char waits in the output register
// until taken; a stalled output holds the sequencer before each char, and the next item
// is taken only once the previous item's last result has left or leaves in that cycle.
module formatted_output_engine_core #(
  parameter int unsigned MaxWidth = foe_pkg::MaxWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] arg_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_char_o,
  output logic        in_buffer_o,
  output logic [15:0] position_o,
  output logic        is_terminator_o,
  output logic [31:0] char_count_o,
  output logic        last_o
);
  import foe_pkg::*;

  foe_cmd_t cmd;
  foe_sts_t sts;
  logic     hex, sgn;

  foe_ctrl #(.MaxWidth(MaxWidth)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .mode_i, .data_byte_i, .arg_value_i,
    .hex_o(hex), .signed_o(sgn), .cmd_o(cmd), .sts_i(sts)
  );

  foe_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .arg_value_i,
    .hex_i(hex), .signed_i(sgn), .cmd_i(cmd), .sts_o(sts),
    .out_ready_i, .out_valid_o, .out_char_o, .in_buffer_o, .position_o,
    .is_terminator_o, .char_count_o, .last_o
  );
endmodule

FILE: rtl/foe_checker.sv
// Port-level checker for the formatted output engine, bound to the top level.
// Depends on formatted_output_engine_core ports only.
module foe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  out_char_o,
  input logic        in_buffer_o,
  input logic [15:0] position_o,
  input logic        is_terminator_o,
  input logic        last_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_char_o))
    else $error("result changed while stalled");
  a_term_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_terminator_o |-> out_char_o == 8'd0 && last_o)
    else $error("terminator malformed");
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_buffer_o |-> position_o == 16'd0)
    else $error("position without buffer");
endmodule

bind formatted_output_engine_core foe_checker u_foe_checker (.*);
